// ===== hdl/rtq_pkg.sv =====
`timescale 1ns / 1ps

package rtq_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int FIELD_W = 18;
	localparam int MAG_W = 19;
	localparam int QUO_W = 19;
	localparam longint OUT_MAX = 131071;
	localparam longint OUT_MIN = -131072;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_XX    = 2'd1,
		BR_YY    = 2'd2,
		BR_ZZ    = 2'd3
	} branch_t;

	typedef struct packed {
		logic [2:0]            neg;
		logic [2:0][MAG_W-1:0] mag;
		branch_t               br;
	} side_t;

	function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [63:0] v);
		if (v > 64'(OUT_MAX)) begin
			return FIELD_W'(OUT_MAX);
		end else if (v < 64'(OUT_MIN)) begin
			return FIELD_W'(OUT_MIN);
		end else begin
			return v[FIELD_W-1:0];
		end
	endfunction

endpackage

// ===== hdl/rotation_to_quaternion.sv =====
`timescale 1ns / 1ps

// Rotation matrix to unit quaternion, trace-based four-branch method. A new
// matrix is taken on every cycle with start high; busy stays low. Each result
// appears on done for one cycle. The depth is set by one input stage, the
// square root (one root bit per stage), one divider setup stage, three
// parallel dividers (one quotient bit per stage, 19 stages) and one output
// stage. Results come in input order and must be taken when done is high.
module rotation_to_quaternion #(
	parameter int FRAC_BITS = rtq_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [17:0]         r00,
	input  logic signed [17:0]         r01,
	input  logic signed [17:0]         r02,
	input  logic signed [17:0]         r10,
	input  logic signed [17:0]         r11,
	input  logic signed [17:0]         r12,
	input  logic signed [17:0]         r20,
	input  logic signed [17:0]         r21,
	input  logic signed [17:0]         r22,
	output logic                       done,
	output logic signed [17:0]         quat_w,
	output logic signed [17:0]         quat_x,
	output logic signed [17:0]         quat_y,
	output logic signed [17:0]         quat_z,
	output logic [1:0]                 branch_used
);

	localparam int AW = (FRAC_BITS + 2 > 22) ? FRAC_BITS + 2 : 22;
	localparam int RW = (AW + FRAC_BITS + 1) / 2;
	localparam int VW = 2 * RW;
	localparam int REMW = RW + 3;
	localparam int QW = rtq_pkg::QUO_W;
	localparam int MW = rtq_pkg::MAG_W + FRAC_BITS + 1;
	localparam int DRW = RW + 2;
	localparam int LAT = RW + QW + 3;

	// stage 1: branch select, radicand, numerators
	logic signed [19:0] trace;
	logic signed [20:0] t_sel;
	logic signed [AW-1:0] a_val;
	logic signed [18:0] d_sel [0:2];
	rtq_pkg::branch_t br_sel;
	rtq_pkg::side_t side_in;

	always_comb begin
		trace = 20'(r00) + 20'(r11) + 20'(r22);
		if (trace > 20'sd0) begin
			br_sel = rtq_pkg::BR_TRACE;
			t_sel = 21'(trace);
			d_sel[0] = 19'(r21) - 19'(r12);
			d_sel[1] = 19'(r02) - 19'(r20);
			d_sel[2] = 19'(r10) - 19'(r01);
		end else if (r00 > r11 && r00 > r22) begin
			br_sel = rtq_pkg::BR_XX;
			t_sel = 21'(r00) - 21'(r11) - 21'(r22);
			d_sel[0] = 19'(r21) - 19'(r12);
			d_sel[1] = 19'(r01) + 19'(r10);
			d_sel[2] = 19'(r02) + 19'(r20);
		end else if (r11 > r22) begin
			br_sel = rtq_pkg::BR_YY;
			t_sel = 21'(r11) - 21'(r00) - 21'(r22);
			d_sel[0] = 19'(r02) - 19'(r20);
			d_sel[1] = 19'(r01) + 19'(r10);
			d_sel[2] = 19'(r12) + 19'(r21);
		end else begin
			br_sel = rtq_pkg::BR_ZZ;
			t_sel = 21'(r22) - 21'(r00) - 21'(r11);
			d_sel[0] = 19'(r10) - 19'(r01);
			d_sel[1] = 19'(r02) + 19'(r20);
			d_sel[2] = 19'(r12) + 19'(r21);
		end
		a_val = (AW'(1) <<< FRAC_BITS) + AW'(t_sel);
		if (a_val < 0) begin
			a_val = '0;
		end
		side_in.br = br_sel;
		for (int i = 0; i < 3; i++) begin
			side_in.neg[i] = d_sel[i][18];
			side_in.mag[i] = d_sel[i][18] ? 19'(-d_sel[i]) : 19'(d_sel[i]);
		end
	end

	logic                  vld_s1;
	logic [VW-1:0]         rad_s1;
	rtq_pkg::side_t        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		rad_s1  <= VW'(a_val) << FRAC_BITS;
		side_s1 <= side_in;
	end

	// square root, one root bit per stage
	logic                  sq_vld_s  [0:RW];
	logic [VW-1:0]         sq_rad_s  [0:RW];
	logic [REMW-1:0]       sq_rem_s  [0:RW];
	logic [RW-1:0]         sq_res_s  [0:RW];
	rtq_pkg::side_t        sq_side_s [0:RW];

	assign sq_vld_s[0]  = vld_s1;
	assign sq_rad_s[0]  = rad_s1;
	assign sq_rem_s[0]  = '0;
	assign sq_res_s[0]  = '0;
	assign sq_side_s[0] = side_s1;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;
		logic            take;

		always_comb begin
			rem_sh = {sq_rem_s[k][REMW-3:0], sq_rad_s[k][VW-1 -: 2]};
			trial  = {sq_res_s[k], 2'b01};
			take   = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
			sq_rem_s[k+1]  <= take ? rem_sh - trial : rem_sh;
			sq_res_s[k+1]  <= {sq_res_s[k][RW-2:0], take};
			sq_side_s[k+1] <= sq_side_s[k];
		end
	end

	// divider setup: S = 2R, numerator = mag * 2^F + R for round to nearest
	logic [RW-1:0]  root;
	logic [MW-1:0]  num [0:2];

	always_comb begin
		root = sq_res_s[RW];
		for (int i = 0; i < 3; i++) begin
			num[i] = (MW'(sq_side_s[RW].mag[i]) << FRAC_BITS) + MW'(root);
		end
	end

	logic                  dv_vld_s  [0:QW];
	logic [RW:0]           dv_div_s  [0:QW];
	logic [RW-1:0]         dv_piv_s  [0:QW];
	logic [2:0][DRW-1:0]   dv_rem_s  [0:QW];
	logic [2:0][QW-1:0]    dv_num_s  [0:QW];
	logic [2:0][QW-1:0]    dv_quo_s  [0:QW];
	rtq_pkg::side_t        dv_side_s [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else begin
			dv_vld_s[0] <= sq_vld_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		dv_div_s[0]  <= {root, 1'b0};
		dv_piv_s[0]  <= RW'(({1'b0, root} + (RW+1)'(1)) >> 1);
		dv_side_s[0] <= sq_side_s[RW];
		dv_quo_s[0]  <= '0;
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= DRW'(num[i] >> QW);
			dv_num_s[0][i] <= num[i][QW-1:0];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [2:0][DRW:0] rem_sh;
		logic [2:0]        take;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_sh[i] = {dv_rem_s[j][i], dv_num_s[j][i][QW-1]};
				take[i]   = rem_sh[i] >= (DRW+1)'(dv_div_s[j]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_div_s[j+1]  <= dv_div_s[j];
			dv_piv_s[j+1]  <= dv_piv_s[j];
			dv_side_s[j+1] <= dv_side_s[j];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[j+1][i] <= take[i] ? DRW'(rem_sh[i] - (DRW+1)'(dv_div_s[j]))
				                            : DRW'(rem_sh[i]);
				dv_num_s[j+1][i] <= dv_num_s[j][i] << 1;
				dv_quo_s[j+1][i] <= {dv_quo_s[j][i][QW-2:0], take[i]};
			end
		end
	end

	// sign, saturate, place the pivot
	logic signed [17:0] piv_sat;
	logic signed [17:0] oth_sat [0:2];
	logic signed [63:0] oth_val;

	always_comb begin
		piv_sat = rtq_pkg::sat_field(64'(dv_piv_s[QW]));
		oth_val = '0;
		for (int i = 0; i < 3; i++) begin
			oth_val = dv_side_s[QW].neg[i] ? -64'(dv_quo_s[QW][i]) : 64'(dv_quo_s[QW][i]);
			oth_sat[i] = rtq_pkg::sat_field(oth_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		branch_used <= dv_side_s[QW].br;
		case (dv_side_s[QW].br)
			rtq_pkg::BR_TRACE: begin
				quat_w <= piv_sat;    quat_x <= oth_sat[0];
				quat_y <= oth_sat[1]; quat_z <= oth_sat[2];
			end
			rtq_pkg::BR_XX: begin
				quat_w <= oth_sat[0]; quat_x <= piv_sat;
				quat_y <= oth_sat[1]; quat_z <= oth_sat[2];
			end
			rtq_pkg::BR_YY: begin
				quat_w <= oth_sat[0]; quat_x <= oth_sat[1];
				quat_y <= piv_sat;    quat_z <= oth_sat[2];
			end
			default: begin
				quat_w <= oth_sat[0]; quat_x <= oth_sat[1];
				quat_y <= oth_sat[2]; quat_z <= piv_sat;
			end
		endcase
	end

	assign busy = 1'b0;

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching start");

	a_pivot_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((branch_used == rtq_pkg::BR_TRACE && !quat_w[17])
		       || (branch_used == rtq_pkg::BR_XX && !quat_x[17])
		       || (branch_used == rtq_pkg::BR_YY && !quat_y[17])
		       || (branch_used == rtq_pkg::BR_ZZ && !quat_z[17])))
		else $error("pivot component negative");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[0] |-> dv_div_s[0][0] == 1'b0)
		else $error("divisor not even");

endmodule
